[design/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// Op codes, fault codes and Q16.16 constants for the RPN calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_SQR  = 4'd5;
  localparam logic [3:0] OP_ROOT = 4'd6;
  localparam logic [3:0] OP_DUP  = 4'd7;
  localparam logic [3:0] OP_SWAP = 4'd8;
  localparam logic [3:0] OP_LIST = 4'd9;

  localparam logic [2:0] F_NONE    = 3'd0;
  localparam logic [2:0] F_FULL    = 3'd1;
  localparam logic [2:0] F_EMPTY   = 3'd2;
  localparam logic [2:0] F_DIVZERO = 3'd3;
  localparam logic [2:0] F_NEGROOT = 3'd4;
  localparam logic [2:0] F_SAT     = 3'd5;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sh1;

  // request to the iterative arithmetic unit
  typedef enum logic [1:0] {
    AU_DIV  = 2'd0,
    AU_ROOT = 2'd1
  } au_op_t;

  typedef struct packed {
    logic                go;
    au_op_t              op;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
  } au_req_t;

  typedef struct packed {
    logic                done;
    logic                sat;
    logic signed [31:0]  res;
  } au_rsp_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v,
                                               output logic sat);
    sat = 1'b0;
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return Q_MAX;
    end else if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

endpackage

[design/rpn_iter.sv]
// ----------------------------------------------------------------------------
// rpn_iter
// Iterative Q16.16 divide (one quotient bit a cycle) and 48-bit integer
// square root (one result bit a cycle).
// ----------------------------------------------------------------------------
module rpn_iter
  import rpn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  au_req_t req,
  output au_rsp_t rsp
);

  logic        busy;
  au_op_t      op;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] num;   // dividend magnitude shifted left / root radicand
  logic [31:0] den;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [48:0] rrem;
  logic [24:0] root;
  logic [48:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] qmag;
  logic        done;
  logic        res_sat;
  logic signed [31:0] res;

  assign rem_sh = {rem[62:0], num[63]};
  assign trial  = {rrem[46:0], num[63:62]} - {22'd0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        op   <= req.op;
        rem  <= '0;
        quo  <= '0;
        rrem <= '0;
        root <= '0;
        if (req.op == AU_DIV) begin
          neg <= req.a[31] ^ req.b[31];
          num <= {16'd0, (req.a[31] ? -req.a : req.a), 16'd0};
          den <= req.b[31] ? -req.b : req.b;
          cnt <= 7'd64;
        end else begin
          num <= {req.a, 32'd0};   // radicand a<<16 placed at the top of 64 bits
          cnt <= 7'd24;
        end
      end else if (busy) begin
        if (op == AU_DIV) begin
          num <= {num[62:0], 1'b0};
          if (rem_sh >= {32'd0, den}) begin
            rem <= rem_sh - {32'd0, den};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
        end else begin
          num <= {num[61:0], 2'b00};
          if (!trial[48]) begin
            rrem <= trial;
            root <= {root[23:0], 1'b1};
          end else begin
            rrem <= {rrem[46:0], num[63:62]};
            root <= {root[23:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // final result: root, or quotient with sign and saturation
  assign qmag = quo;
  always_comb begin
    res_sat = 1'b0;
    res     = {7'd0, root};
    if (op == AU_DIV) begin
      if (neg) begin
        if (qmag > 64'h8000_0000) begin
          res_sat = 1'b1;
          res     = Q_MIN;
        end else begin
          res = -qmag[31:0];
        end
      end else if (qmag > 64'h7FFF_FFFF) begin
        res_sat = 1'b1;
        res     = Q_MAX;
      end else begin
        res = qmag[31:0];
      end
    end
  end

  assign rsp = {done, res_sat, res};

endmodule

[design/rpn_stack_calculator_core.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Q16.16 RPN operand stack held in a synchronous RAM, with folds, square,
// root, dup, swap and list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the last result of that request is on valid. Results cannot be
// stalled. Root uses the 24-step root unit, and a divide fold runs the
// 64-step divider once per entry; a divide by zero leaves the stack
// untouched. List gives one result per entry from the top down. RAM reads
// are registered.
module rpn_stack_calculator_core
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op,
  input  logic signed [31:0] value,
  output logic               valid,
  output logic signed [31:0] top_value,
  output logic [5:0]         stack_depth,
  output logic               is_entry,
  output logic [2:0]         fault,
  output logic               last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  // internal op used to re-read the top for the status result
  localparam logic [3:0] OP_NONE = 4'd15;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_EXEC = 8'b0000_0100,
    S_WAIT = 8'b0000_1000,
    S_WR   = 8'b0001_0000,
    S_STAT = 8'b0010_0000,
    S_LIST = 8'b0100_0000,
    S_FOLD = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [3:0]         cur_op;
  logic signed [31:0] cur_val;
  logic [CW-1:0]      count;
  logic [CW-1:0]      pushed;
  logic [CW-1:0]      idx;     // fold / list step
  logic [CW-1:0]      n;
  logic signed [31:0] acc;
  logic signed [31:0] tmp;
  logic               sat;
  logic               step;    // second read of swap, fold / list read phase

  logic signed [31:0] mem [STACK_DEPTH];
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic signed [31:0] wdata;
  logic signed [31:0] rdata;

  au_req_t            au_req;
  au_rsp_t            au_rsp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  rpn_iter u_iter (.clk(clk), .rst(rst), .req(au_req), .rsp(au_rsp));

  function automatic logic [AW-1:0] a_of(input logic [CW-1:0] c);
    return c[AW-1:0];
  endfunction

  logic signed [63:0] prod;
  logic signed [63:0] sum;
  logic signed [31:0] sv;
  logic               ss;
  logic signed [31:0] mv;
  logic               ms;

  always_comb begin
    prod = 64'(acc) * 64'(rdata);
    mv   = sat64(prod >>> 16, ms);
    if (cur_op == OP_ADD) begin
      sum = 64'(acc) + 64'(rdata);
    end else begin
      sum = 64'(rdata) - 64'(acc);
    end
    sv = sat64(sum, ss);
  end

  assign busy = (state != S_IDLE);
  assign stack_depth = 6'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pushed <= '0;
      valid  <= 1'b0;
      we     <= 1'b0;
      au_req.go <= 1'b0;
    end else begin
      valid     <= 1'b0;
      we        <= 1'b0;
      au_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op  <= op;
            cur_val <= value;
            fault   <= F_NONE;
            sat     <= 1'b0;
            step    <= 1'b0;
            idx     <= '0;
            n       <= (pushed > count) ? count : pushed;
            raddr   <= a_of(count - 1'b1);
            state   <= S_RD;
          end
        end
        S_RD: state <= S_EXEC;   // read latency
        S_EXEC: begin
          state <= S_STAT;
          case (cur_op)
            OP_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                fault <= F_FULL;
              end else begin
                we <= 1'b1; waddr <= a_of(count); wdata <= cur_val;
                count <= count + 1'b1;
                if (pushed != CW'(STACK_DEPTH)) pushed <= pushed + 1'b1;
                state <= S_WR;
              end
            end
            OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
              if (n == '0) begin
                if (cur_op == OP_SUB || cur_op == OP_DIV) begin
                  fault <= F_EMPTY;
                end else begin
                  pushed <= '0;
                  if (count == CW'(STACK_DEPTH)) begin
                    fault <= F_FULL;
                  end else begin
                    we <= 1'b1; waddr <= a_of(count);
                    wdata <= (cur_op == OP_MUL) ? Q_ONE : '0;
                    count <= count + 1'b1;
                    state <= S_WR;
                  end
                end
              end else begin
                if (cur_op == OP_ADD || cur_op == OP_MUL) begin
                  acc <= (cur_op == OP_MUL) ? Q_ONE : '0;
                  idx <= '0;
                  raddr <= a_of(count - 1'b1);
                end else begin
                  acc <= rdata;
                  idx <= CW'(1);
                  raddr <= a_of(count - 2'd2);
                end
                state <= S_FOLD;
                step  <= 1'b0;
              end
            end
            OP_SQR: begin
              if (count == '0) begin
                fault <= F_EMPTY;
              end else begin
                acc <= rdata;
                cur_op <= OP_SQR;
                idx <= '0;
                state <= S_WAIT;
              end
            end
            OP_ROOT: begin
              if (count == '0) begin
                fault <= F_EMPTY;
              end else if (rdata[31]) begin
                fault <= F_NEGROOT;
              end else begin
                au_req.go <= 1'b1; au_req.op <= AU_ROOT; au_req.a <= rdata;
                au_req.b <= '0;
                state <= S_WAIT;
              end
            end
            OP_DUP: begin
              if (count == '0) begin
                fault <= F_EMPTY;
              end else if (count == CW'(STACK_DEPTH)) begin
                fault <= F_FULL;
              end else begin
                we <= 1'b1; waddr <= a_of(count); wdata <= rdata;
                count <= count + 1'b1;
                state <= S_WR;
              end
            end
            OP_SWAP: begin
              if (count < CW'(2)) begin
                fault <= F_EMPTY;
              end else if (!step) begin
                tmp <= rdata;
                step <= 1'b1;
                raddr <= a_of(count - 2'd2);
                state <= S_RD;
              end else begin
                we <= 1'b1; waddr <= a_of(count - 1'b1); wdata <= rdata;
                acc <= tmp;
                state <= S_WAIT;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                fault <= F_EMPTY;
              end else begin
                idx <= '0;
                raddr <= a_of(count - 1'b1);
                state <= S_LIST;
                step <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_WAIT: begin
          // finishing square, root and swap, and divide fold steps
          if (cur_op == OP_SQR) begin
            we <= 1'b1; waddr <= a_of(count - 1'b1); wdata <= mv;
            if (ms) fault <= F_SAT;
            state <= S_WR;
          end else if (cur_op == OP_SWAP) begin
            we <= 1'b1; waddr <= a_of(count - 2'd2); wdata <= acc;
            state <= S_WR;
          end else if (au_rsp.done) begin
            if (cur_op == OP_DIV) begin
              acc   <= au_rsp.res;
              sat   <= sat | au_rsp.sat;
              idx   <= idx + 1'b1;
              raddr <= a_of(count - idx - 2'd2);
              step  <= 1'b0;
              state <= S_FOLD;
            end else begin
              we <= 1'b1; waddr <= a_of(count - 1'b1); wdata <= au_rsp.res;
              state <= S_WR;
            end
          end
        end
        S_WR: begin
          raddr <= a_of(count - 1'b1);
          state <= S_RD;
          cur_op <= OP_NONE;   // re-read top for status
        end
        S_FOLD: begin
          // step: 0 wait for the read, 1 data valid / divide issued
          if (!step) begin
            step <= 1'b1;
          end else if (idx == n) begin
            we <= 1'b1; waddr <= a_of(count - n); wdata <= acc;
            count <= count - n + 1'b1;
            pushed <= '0;
            if (sat) fault <= F_SAT;
            state <= S_WR;
          end else begin
            case (cur_op)
              OP_ADD: begin acc <= sv; sat <= sat | ss; end
              OP_SUB: begin acc <= sv; sat <= sat | ss; end
              OP_MUL: begin acc <= mv; sat <= sat | ms; end
              default: ;
            endcase
            if (cur_op == OP_DIV) begin
              if (acc == '0) begin
                // stack untouched; re-read top for the status
                fault <= F_DIVZERO;
                state <= S_WR;
              end else begin
                au_req.go <= 1'b1; au_req.op <= AU_DIV;
                au_req.a <= rdata; au_req.b <= acc;
                state <= S_WAIT;
                cur_op <= OP_DIV;
              end
            end else begin
              idx <= idx + 1'b1;
              raddr <= a_of(count - idx - 2'd2);
              step <= 1'b0;
            end
          end
        end
        S_LIST: begin
          if (!step) begin
            step <= 1'b1;
          end else begin
            valid     <= 1'b1;
            top_value <= rdata;
            is_entry  <= 1'b1;
            fault     <= F_NONE;
            last      <= (idx + 1'b1 == count);
            if (idx + 1'b1 == count) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              raddr <= a_of(count - idx - 2'd2);
              step  <= 1'b0;
            end
          end
        end
        S_STAT: begin
          valid     <= 1'b1;
          top_value <= (count == '0) ? '0 : rdata;
          is_entry  <= 1'b0;
          last      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
